// ===== hdl/orm_pkg.sv =====
// ----------------------------------------------------------------------------
// orm_pkg
// Shared types for the overwriting frame ring: request codes, result select,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package orm_pkg;

    typedef enum logic [2:0] {
        ACT_WRITE    = 3'd0,
        ACT_SILENCE  = 3'd1,
        ACT_READ     = 3'd2,
        ACT_SKIP     = 3'd3,
        ACT_INIT_OLD = 3'd4,
        ACT_INIT_NEW = 3'd5,
        ACT_SEEK     = 3'd6
    } act_t;

    typedef enum logic [1:0] {
        EMIT_NONE   = 2'd0,
        EMIT_CURSOR = 2'd1,
        EMIT_ZERO   = 2'd2,
        EMIT_READER = 2'd3
    } emit_t;

    typedef struct packed {
        logic  latch;
        logic  wr_frame;
        logic  wr_zero;
        logic  load;
        logic  catch_up;
        logic  init_old;
        logic  init_new;
        logic  seek;
        logic  calc_avail;
        logic  advance;
        logic  rd_issue;
        logic  rd_last;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic [6:0] n;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/orm_ram.sv =====
// ----------------------------------------------------------------------------
// orm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module orm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/orm_ctrl.sv =====
// ----------------------------------------------------------------------------
// orm_ctrl
// Request sequencer: decodes requests; reads and skips step the datapath
// through catch-up, availability, advance and the read loop (reads only).
// ----------------------------------------------------------------------------
`default_nettype none

module orm_ctrl #(
    parameter int READERS = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [2:0]    action,
    input  wire logic [1:0]    reader_id,
    input  wire logic [6:0]    count,
    output logic               busy,
    output orm_pkg::cmd_t      cmd,
    input  wire orm_pkg::sts_t sts
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SIL   = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_CATCH = 9'b000001000,
        ST_AVAIL = 9'b000010000,
        ST_ADV   = 9'b000100000,
        ST_READ  = 9'b001000000,
        ST_WAIT  = 9'b010000000,
        ST_FIN   = 9'b100000000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [6:0]      cnt_reg;
    logic [6:0]      cnt_next;
    orm_pkg::act_t   act_reg;
    orm_pkg::act_t   act_next;
    logic            rid_ok;
    logic            accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign rid_ok = (32'(reader_id) < READERS);

    always_comb
    begin
        cmd        = '0;
        cmd.emit   = orm_pkg::EMIT_NONE;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        act_next   = act_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == orm_pkg::ACT_WRITE)
                    begin
                        cmd.wr_frame = 1'b1;
                        cmd.emit     = orm_pkg::EMIT_CURSOR;
                    end
                    else if (action == orm_pkg::ACT_SILENCE)
                    begin
                        if (count == 7'd0)
                        begin
                            cmd.emit = orm_pkg::EMIT_CURSOR;
                        end
                        else
                        begin
                            cnt_next   = count;
                            state_next = ST_SIL;
                        end
                    end
                    else if ((action inside {[orm_pkg::ACT_READ:orm_pkg::ACT_SEEK]}) && rid_ok)
                    begin
                        cmd.latch  = 1'b1;
                        act_next   = orm_pkg::act_t'(action);
                        cnt_next   = count;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.emit = orm_pkg::EMIT_ZERO;
                    end
                end
            end
            ST_SIL:
            begin
                cmd.wr_zero = 1'b1;
                cnt_next    = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    cmd.emit   = orm_pkg::EMIT_CURSOR;
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_CATCH;
            end
            ST_CATCH:
            begin
                case (act_reg)
                    orm_pkg::ACT_READ, orm_pkg::ACT_SKIP:
                    begin
                        if (cnt_reg == 7'd0)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            cmd.catch_up = 1'b1;
                            state_next   = ST_AVAIL;
                        end
                    end
                    orm_pkg::ACT_INIT_OLD:
                    begin
                        cmd.init_old = 1'b1;
                        state_next   = ST_FIN;
                    end
                    orm_pkg::ACT_INIT_NEW:
                    begin
                        cmd.init_new = 1'b1;
                        state_next   = ST_FIN;
                    end
                    default:
                    begin
                        cmd.seek   = 1'b1;
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_AVAIL:
            begin
                cmd.calc_avail = 1'b1;
                state_next     = ST_ADV;
            end
            ST_ADV:
            begin
                cmd.advance = 1'b1;
                if ((act_reg == orm_pkg::ACT_READ) && (sts.n != 7'd0))
                begin
                    cnt_next   = sts.n;
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                cmd.rd_last  = (cnt_reg == 7'd1);
                cnt_next     = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_FIN:
            begin
                cmd.emit   = orm_pkg::EMIT_READER;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 7'd0;
            act_reg   <= orm_pkg::ACT_WRITE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            act_reg   <= act_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/orm_dp.sv =====
// ----------------------------------------------------------------------------
// orm_dp
// Ring datapath: write cursor, reader positions and loss totals, frame RAM,
// cursor arithmetic and the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module orm_dp #(
    parameter int DEPTH      = 1024,
    parameter int FRAME_BITS = 32,
    parameter int READERS    = 4,
    parameter int MAX_BURST  = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire orm_pkg::cmd_t cmd,
    output orm_pkg::sts_t      sts,
    input  wire logic [1:0]    reader_id,
    input  wire logic [31:0]   frame_data,
    input  wire logic [6:0]    count,
    input  wire logic [63:0]   target_pos,
    output logic               result_valid,
    output logic [31:0]        frame_out,
    output logic               has_frame,
    output logic [63:0]        lost_frames,
    output logic [6:0]         moved,
    output logic [63:0]        position,
    output logic               last
);

    localparam int          AW      = $clog2(DEPTH);
    localparam int          RID_W   = (READERS > 1) ? $clog2(READERS) : 1;
    localparam logic [63:0] DEPTH64 = 64'(DEPTH);
    localparam logic [6:0]  BURST7  = 7'(MAX_BURST);

    logic [63:0]           cursor_reg;
    logic [63:0]           cursor_next;
    logic [AW-1:0]         widx_reg;
    logic [AW-1:0]         widx_next;
    logic [63:0]           pos_arr_reg  [READERS];
    logic [63:0]           loss_arr_reg [READERS];
    logic                  rdv_reg;
    logic                  rdl_reg;
    logic                  valid_reg;

    logic [RID_W-1:0]      rid_reg;
    logic [6:0]            cnt_reg;
    logic [63:0]           target_reg;
    logic [63:0]           pos_reg;
    logic [63:0]           gap_reg;
    logic [63:0]           wsub_reg;
    logic [63:0]           oldest_reg;
    logic [63:0]           clost_reg;
    logic [6:0]            n_reg;
    logic [AW:0]           diff_reg;
    logic [AW-1:0]         rd_idx_reg;

    logic [31:0]           frame_reg;
    logic                  has_reg;
    logic [63:0]           lost_reg;
    logic [6:0]            moved_reg;
    logic [63:0]           position_reg;
    logic                  last_reg;

    logic                  wr_en;
    logic [FRAME_BITS-1:0] wr_data;
    logic [FRAME_BITS-1:0] ram_q;
    logic [63:0]           wsub;
    logic [63:0]           pos_sel;
    logic [63:0]           seek_pos;
    logic [63:0]           diff;
    logic [6:0]            want;
    logic [63:0]           after;
    logic [AW:0]           widx_x;
    logic [AW-1:0]         rd_start;
    logic [AW-1:0]         rd_idx_inc;

    assign wr_en       = cmd.wr_frame || cmd.wr_zero;
    assign wr_data     = cmd.wr_frame ? FRAME_BITS'(frame_data) : '0;
    assign cursor_next = cursor_reg + 64'(wr_en);
    assign widx_next   = (widx_reg == AW'(DEPTH - 1)) ? '0 : widx_reg + 1'b1;
    assign wsub        = cursor_reg - DEPTH64;
    assign pos_sel     = pos_arr_reg[rid_reg];
    assign seek_pos    = (target_reg < oldest_reg) ? oldest_reg :
                         (target_reg > cursor_reg) ? cursor_reg : target_reg;
    assign diff        = cursor_reg - pos_reg;
    assign want        = (cnt_reg > BURST7) ? BURST7 : cnt_reg;
    assign after       = pos_reg + 64'(n_reg);
    assign widx_x      = {1'b0, widx_reg};
    assign rd_start    = (widx_x >= diff_reg) ? AW'(widx_x - diff_reg)
                                              : AW'(widx_x + (AW+1)'(DEPTH) - diff_reg);
    assign rd_idx_inc  = (rd_idx_reg == AW'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
    assign sts.n       = n_reg;

    orm_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (widx_reg),
        .wdata (wr_data),
        .re    (cmd.rd_issue),
        .raddr (rd_idx_reg),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            widx_reg   <= '0;
            rdv_reg    <= 1'b0;
            rdl_reg    <= 1'b0;
            valid_reg  <= 1'b0;
            for (int i = 0; i < READERS; i++)
            begin
                pos_arr_reg[i]  <= '0;
                loss_arr_reg[i] <= '0;
            end
        end
        else
        begin
            cursor_reg <= cursor_next;
            if (wr_en)
            begin
                widx_reg <= widx_next;
            end
            rdv_reg   <= cmd.rd_issue;
            rdl_reg   <= cmd.rd_last;
            valid_reg <= (cmd.emit != orm_pkg::EMIT_NONE) || rdv_reg;
            if (cmd.init_old)
            begin
                pos_arr_reg[rid_reg]  <= oldest_reg;
                loss_arr_reg[rid_reg] <= '0;
            end
            if (cmd.init_new)
            begin
                pos_arr_reg[rid_reg]  <= cursor_reg;
                loss_arr_reg[rid_reg] <= '0;
            end
            if (cmd.seek)
            begin
                pos_arr_reg[rid_reg] <= seek_pos;
            end
            if (cmd.calc_avail)
            begin
                loss_arr_reg[rid_reg] <= loss_arr_reg[rid_reg] + clost_reg;
            end
            if (cmd.advance)
            begin
                pos_arr_reg[rid_reg] <= after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            rid_reg    <= RID_W'(reader_id);
            cnt_reg    <= count;
            target_reg <= target_pos;
            clost_reg  <= '0;
            n_reg      <= '0;
        end
        if (cmd.load)
        begin
            pos_reg    <= pos_sel;
            gap_reg    <= cursor_reg - pos_sel;
            wsub_reg   <= wsub;
            oldest_reg <= (cursor_reg > DEPTH64) ? wsub : '0;
        end
        if (cmd.catch_up && (gap_reg > DEPTH64))
        begin
            clost_reg <= gap_reg - DEPTH64;
            pos_reg   <= wsub_reg;
        end
        if (cmd.init_old)
        begin
            pos_reg <= oldest_reg;
        end
        if (cmd.init_new)
        begin
            pos_reg <= cursor_reg;
        end
        if (cmd.seek)
        begin
            pos_reg <= seek_pos;
        end
        if (cmd.calc_avail)
        begin
            if (cursor_reg > pos_reg)
            begin
                n_reg    <= (diff < 64'(want)) ? diff[6:0] : want;
                diff_reg <= (AW+1)'(diff);
            end
            else
            begin
                n_reg    <= '0;
                diff_reg <= '0;
            end
        end
        if (cmd.advance)
        begin
            pos_reg    <= after;
            rd_idx_reg <= rd_start;
        end
        if (cmd.rd_issue)
        begin
            rd_idx_reg <= rd_idx_inc;
        end

        if (rdv_reg)
        begin
            frame_reg    <= 32'(ram_q);
            has_reg      <= 1'b1;
            lost_reg     <= rdl_reg ? clost_reg : '0;
            moved_reg    <= n_reg;
            position_reg <= pos_reg;
            last_reg     <= rdl_reg;
        end
        else
        begin
            case (cmd.emit)
                orm_pkg::EMIT_CURSOR:
                begin
                    frame_reg    <= '0;
                    has_reg      <= 1'b0;
                    lost_reg     <= '0;
                    moved_reg    <= '0;
                    position_reg <= cursor_next;
                    last_reg     <= 1'b1;
                end
                orm_pkg::EMIT_ZERO:
                begin
                    frame_reg    <= '0;
                    has_reg      <= 1'b0;
                    lost_reg     <= '0;
                    moved_reg    <= '0;
                    position_reg <= '0;
                    last_reg     <= 1'b1;
                end
                orm_pkg::EMIT_READER:
                begin
                    frame_reg    <= '0;
                    has_reg      <= 1'b0;
                    lost_reg     <= clost_reg;
                    moved_reg    <= n_reg;
                    position_reg <= pos_reg;
                    last_reg     <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = valid_reg;
    assign frame_out    = frame_reg;
    assign has_frame    = has_reg;
    assign lost_frames  = lost_reg;
    assign moved        = moved_reg;
    assign position     = position_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== hdl/overwrite_ring_multi_reader.sv =====
// ----------------------------------------------------------------------------
// overwrite_ring_multi_reader
// Overwriting frame ring with one producer and several lapped-reader cursors.
// ----------------------------------------------------------------------------
// Frame write: accepted every cycle while not busy, result strobed the cycle after accept.
// Silence of N frames: N zero frames written, one RAM write per cycle, result at end.
// Read of n frames: load, catch-up, availability and advance steps, then one
//   frame per cycle from the single RAM read port.
// Skip: result after load, catch-up, availability, advance; init, seek: after load.
// Reset clears cursors and loss totals at once; the frame RAM is not cleared.
`default_nettype none

module overwrite_ring_multi_reader #(
    parameter int DEPTH      = 1024,
    parameter int FRAME_BITS = 32,
    parameter int READERS    = 4,
    parameter int MAX_BURST  = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  action,
    input  wire logic [1:0]  reader_id,
    input  wire logic [31:0] frame_data,
    input  wire logic [6:0]  count,
    input  wire logic [63:0] target_pos,
    output logic             result_valid,
    output logic [31:0]      frame_out,
    output logic             has_frame,
    output logic [63:0]      lost_frames,
    output logic [6:0]       moved,
    output logic [63:0]      position,
    output logic             last
);

    orm_pkg::cmd_t cmd;
    orm_pkg::sts_t sts;

    orm_ctrl #(
        .READERS (READERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .reader_id (reader_id),
        .count     (count),
        .busy      (busy),
        .cmd       (cmd),
        .sts       (sts)
    );

    orm_dp #(
        .DEPTH      (DEPTH),
        .FRAME_BITS (FRAME_BITS),
        .READERS    (READERS),
        .MAX_BURST  (MAX_BURST)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .reader_id    (reader_id),
        .frame_data   (frame_data),
        .count        (count),
        .target_pos   (target_pos),
        .result_valid (result_valid),
        .frame_out    (frame_out),
        .has_frame    (has_frame),
        .lost_frames  (lost_frames),
        .moved        (moved),
        .position     (position),
        .last         (last)
    );

endmodule

`default_nettype wire

// ===== hdl/orm_checker.sv =====
// ----------------------------------------------------------------------------
// orm_checker
// Port-level checks on request/result timing and result fields of the frame ring.
// ----------------------------------------------------------------------------
`default_nettype none

module orm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [2:0]  action,
    input wire logic        result_valid,
    input wire logic [31:0] frame_out,
    input wire logic        has_frame,
    input wire logic [6:0]  moved,
    input wire logic        last
);

    // read bursts come out back to back
    a_burst_contig: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("read burst broken");

    a_nonlast_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> has_frame)
        else $error("non-final result without frame");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !has_frame |-> (frame_out == 32'd0))
        else $error("frame_out nonzero without frame");

    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action == orm_pkg::ACT_WRITE)
        |=> result_valid && last && !has_frame)
        else $error("frame write result missing");

    a_frame_moved: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && has_frame |-> (moved != 7'd0))
        else $error("frame with zero move count");

endmodule

bind overwrite_ring_multi_reader orm_checker u_orm_checker (.*);

`default_nettype wire
